FILE: rtl/stp_pkg.sv
package stp_pkg;

   localparam int COLUMNS_DEF      = 128;
   localparam int HALF_COLUMNS_DEF = 64;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0] PAGE_CMD = 8'hB8;
   localparam logic [7:0] COL_CMD  = 8'h40;
   localparam logic [7:0] AXIS_BIT = 8'h01;

   localparam logic [7:0] CHAR_GAIN_UP    = 8'h31;
   localparam logic [7:0] CHAR_GAIN_DOWN  = 8'h32;
   localparam logic [7:0] CHAR_OFFSET_UP  = 8'h33;
   localparam logic [7:0] CHAR_OFFSET_DN  = 8'h34;
   localparam logic [7:0] CHAR_SWEEP      = 8'h21;

   localparam logic [7:0]        GAIN_RESET = 8'd10;
   localparam logic [7:0]        GAIN_MAX   = 8'd255;
   localparam logic signed [7:0] OFFSET_MAX = 8'sd127;
   localparam logic signed [7:0] OFFSET_MIN = -8'sd128;

   localparam logic [5:0] ROW_MAX     = 6'd63;
   localparam logic [5:0] ROW_AXIS_LO = 6'd33;
   localparam logic [5:0] ROW_AXIS_HI = 6'd39;
   localparam logic [2:0] PAGE_AXIS   = 3'd4;

   localparam int JOB_W = 24;

   typedef struct packed {
      logic [7:0]        sample;
      logic [7:0]        gain;
      logic signed [7:0] offset;
   } job_type;

endpackage

FILE: rtl/stp_ram.sv
module stp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: rtl/stp_queue.sv
module stp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/stp_front.sv
module stp_front
   import stp_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,
   output logic                       push,
   output job_type                    push_job,
   output logic [$clog2(COLUMNS)-1:0] push_col,
   input  logic                       full
);

   localparam int COL_W = $clog2(COLUMNS);

   logic                    sweep_ff, sweep_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [7:0]              gain_ff, gain_in;
   logic signed [7:0]       offset_ff, offset_in;
   logic                    take;

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;
   assign push       = take && sweep_ff;

   assign push_job.sample = req_tdata;
   assign push_job.gain   = gain_ff;
   assign push_job.offset = offset_ff;
   assign push_col        = col_ff;

   always_comb begin
      sweep_in  = sweep_ff;
      col_in    = col_ff;
      gain_in   = gain_ff;
      offset_in = offset_ff;
      if (take) begin
         if (sweep_ff) begin
            if (col_ff == COL_W'(COLUMNS - 1)) begin
               col_in   = '0;
               sweep_in = 1'b0;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            case (req_tdata)
               CHAR_GAIN_UP: begin
                  if (gain_ff != GAIN_MAX) gain_in = gain_ff + 1'b1;
               end
               CHAR_GAIN_DOWN: begin
                  if (gain_ff != '0) gain_in = gain_ff - 1'b1;
               end
               CHAR_OFFSET_UP: begin
                  if (offset_ff != OFFSET_MAX) offset_in = offset_ff + 8'sd1;
               end
               CHAR_OFFSET_DN: begin
                  if (offset_ff != OFFSET_MIN) offset_in = offset_ff - 8'sd1;
               end
               CHAR_SWEEP: begin
                  sweep_in = 1'b1;
                  col_in   = '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= 1'b0;
         col_ff    <= '0;
         gain_ff   <= GAIN_RESET;
         offset_ff <= '0;
      end else begin
         sweep_ff  <= sweep_in;
         col_ff    <= col_in;
         gain_ff   <= gain_in;
         offset_ff <= offset_in;
      end
   end

endmodule

FILE: rtl/stp_back.sv
module stp_back
   import stp_pkg::*;
#(
   parameter int COLUMNS      = COLUMNS_DEF,
   parameter int HALF_COLUMNS = HALF_COLUMNS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       empty,
   output logic                       pop,
   input  job_type                    pop_job,
   input  logic [$clog2(COLUMNS)-1:0] pop_col,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int COL_W = $clog2(COLUMNS);

   typedef enum logic [5:0] {
      ERASE_PAGE = 6'b000001,
      ERASE_COL  = 6'b000010,
      ERASE_DATA = 6'b000100,
      PLOT_PAGE  = 6'b001000,
      PLOT_COL   = 6'b010000,
      PLOT_DATA  = 6'b100000
   } step_type;

   // prep stage
   logic                    a_valid_ff, a_valid_in;
   logic [COL_W-1:0]        a_col_ff;
   logic signed [17:0]      a_num_ff, a_num_in;
   logic [15:0]             prod;
   logic signed [14:0]      off100;
   logic [5:0]              ram_rd;
   logic [COLUMNS-1:0]      vld_ff;

   logic                    a_chip, a_hidden, a_plot, a_leave;
   logic [COL_W-1:0]        a_caddr;
   logic [5:0]              a_old, a_row, a_q;
   logic [16:0]             q_prod;

   // emit stage
   logic                    b_busy_ff, b_busy_in;
   step_type                step_ff, step_in;
   logic                    b_chip_ff;
   logic [COL_W-1:0]        b_caddr_ff;
   logic [2:0]              b_old_page_ff;
   logic [5:0]              b_row_ff;
   logic                    b_plot_ff;
   logic                    b_free, b_load, b_xfer;
   logic [7:0]              plot_byte;

   assign prod     = pop_job.sample * pop_job.gain;
   assign off100   = 15'(pop_job.offset) * 15'sd100;
   assign a_num_in = $signed({2'b00, prod}) + 18'(off100);

   assign a_chip   = (32'(a_col_ff) < HALF_COLUMNS);
   assign a_caddr  = a_chip ? a_col_ff : a_col_ff - COL_W'(HALF_COLUMNS);
   assign a_hidden = a_chip && (32'(a_col_ff) == HALF_COLUMNS - 1);
   assign a_plot   = (a_num_ff > -18'sd40) && (a_num_ff < 18'sd2560);
   assign q_prod   = 17'(a_num_ff[11:3]) * 17'd205;
   assign a_q      = (a_num_ff > 18'sd0) ? q_prod[15:10] : 6'd0;
   assign a_row    = ROW_MAX - a_q;
   assign a_old    = vld_ff[a_col_ff] ? ram_rd : 6'd0;

   assign b_xfer  = rsp_tvalid && rsp_tready;
   assign b_free  = !b_busy_ff || (b_xfer && rsp_tlast);
   assign a_leave = a_valid_ff && (a_hidden || b_free);
   assign b_load  = a_valid_ff && !a_hidden && b_free;
   assign pop     = !empty && (!a_valid_ff || a_leave);

   stp_ram #(
      .WIDTH (6),
      .DEPTH (COLUMNS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (a_leave && a_plot),
      .wr_addr (a_col_ff),
      .wr_data (a_row),
      .rd_en   (pop),
      .rd_addr (pop_col),
      .rd_data (ram_rd)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      if (pop) begin
         a_valid_in = 1'b1;
      end else if (a_leave) begin
         a_valid_in = 1'b0;
      end
   end

   always_comb begin
      b_busy_in = b_busy_ff;
      step_in   = step_ff;
      if (b_load) begin
         b_busy_in = 1'b1;
         step_in   = ERASE_PAGE;
      end else if (b_xfer) begin
         if (rsp_tlast) begin
            b_busy_in = 1'b0;
         end else begin
            case (step_ff)
               ERASE_PAGE: step_in = ERASE_COL;
               ERASE_COL:  step_in = ERASE_DATA;
               ERASE_DATA: step_in = PLOT_PAGE;
               PLOT_PAGE:  step_in = PLOT_COL;
               PLOT_COL:   step_in = PLOT_DATA;
               default:    step_in = ERASE_PAGE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_busy_ff  <= 1'b0;
         step_ff    <= ERASE_PAGE;
         vld_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_busy_ff  <= b_busy_in;
         step_ff    <= step_in;
         if (a_leave && a_plot) begin
            vld_ff[a_col_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_col_ff <= pop_col;
         a_num_ff <= a_num_in;
      end
      if (b_load) begin
         b_chip_ff     <= a_chip;
         b_caddr_ff    <= a_caddr;
         b_old_page_ff <= a_old[5:3];
         b_row_ff      <= a_row;
         b_plot_ff     <= a_plot;
      end
   end

   assign plot_byte = (8'd1 << b_row_ff[2:0])
                    | (((b_row_ff >= ROW_AXIS_LO) && (b_row_ff <= ROW_AXIS_HI)) ? AXIS_BIT : 8'd0);

   assign rsp_tvalid   = b_busy_ff;
   assign rsp_tuser[0] = b_chip_ff;
   assign rsp_tuser[1] = (step_ff == ERASE_DATA) || (step_ff == PLOT_DATA);
   assign rsp_tlast    = (step_ff == PLOT_DATA) || ((step_ff == ERASE_DATA) && !b_plot_ff);

   always_comb begin
      case (step_ff)
         ERASE_PAGE: rsp_tdata = PAGE_CMD + {5'd0, b_old_page_ff};
         ERASE_COL:  rsp_tdata = COL_CMD + 8'(b_caddr_ff);
         ERASE_DATA: rsp_tdata = (b_old_page_ff == PAGE_AXIS) ? AXIS_BIT : 8'd0;
         PLOT_PAGE:  rsp_tdata = PAGE_CMD + {5'd0, b_row_ff[5:3]};
         PLOT_COL:   rsp_tdata = COL_CMD + 8'(b_caddr_ff);
         PLOT_DATA:  rsp_tdata = plot_byte;
         default:    rsp_tdata = 8'd0;
      endcase
   end

endmodule

FILE: rtl/scope_trace_plotter.sv
// Channel   Dir  Signals                          Contents
// req       in   req_tvalid/tready/tdata[7:0]     received byte (command or sample)
// rsp       out  rsp_tvalid/tready/tdata/tuser/   one display bus write per transaction,
//                tlast                            tlast on the final write of a byte
//
// A sample yields up to six writes, one per cycle while rsp_tready is high; the emit
// sequencer takes the next sample with the last write of the current one. Commands and
// hidden-column samples yield no writes. Queue, prep and emit stages precede a write.
// Reset clears control state and the per-column valid bits at once; no clearing pass.
// A four-entry queue between front and back accepts until full while rsp is stalled.
module scope_trace_plotter
   import stp_pkg::*;
#(
   parameter int COLUMNS      = COLUMNS_DEF,
   parameter int HALF_COLUMNS = HALF_COLUMNS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] bus_byte
   output logic [1:0] rsp_tuser,   // [0] chip_sel, [1] is_data
   output logic       rsp_tlast
);

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ENT_W = JOB_W + COL_W;

   logic             push, pop, full, empty;
   job_type          push_job, pop_job;
   logic [COL_W-1:0] push_col, pop_col;
   logic [ENT_W-1:0] pop_entry;

   stp_front #(
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_job   (push_job),
      .push_col   (push_col),
      .full       (full)
   );

   stp_queue #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_col, push_job}),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_entry),
      .empty     (empty)
   );

   assign pop_job = pop_entry[JOB_W-1:0];
   assign pop_col = pop_entry[ENT_W-1:JOB_W];

   stp_back #(
      .COLUMNS      (COLUMNS),
      .HALF_COLUMNS (HALF_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .pop        (pop),
      .pop_job    (pop_job),
      .pop_col    (pop_col),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_cmd_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> !rsp_tlast)
      else $error("command write marked last");

   a_plot_follows_erase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[1] && !rsp_tlast
      |=> rsp_tvalid && !rsp_tuser[1])
      else $error("plot sequence did not follow erase");

   a_chip_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tuser[0] == $past(rsp_tuser[0]))
      else $error("chip select changed within a point");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue overflow");

endmodule

FILE: verif/scope_trace_plotter_tb.sv
`timescale 1ns / 100ps

module scope_trace_plotter_tb;
   import stp_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [7:0] CMD_CHARS [5] = '{CHAR_GAIN_UP, CHAR_GAIN_DOWN, CHAR_OFFSET_UP,
                                            CHAR_OFFSET_DN, CHAR_SWEEP};
   // gain 1, offset -1: small negative sums, the -40 boundary, commands as samples
   localparam logic [7:0] PROBE_SAMPLES [7] = '{8'd80, 8'd99, 8'd60, 8'd255, 8'd0,
                                                CHAR_GAIN_UP, CHAR_SWEEP};

   typedef struct packed {
      logic       chip_sel;
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } bus_write_type;

   class plot_scoreboard;
      bit               sweep_on;
      bit [6:0]         next_col;
      bit [7:0]         gain;
      logic signed [7:0] offset;
      bit [5:0]         trace_row [COLUMNS_DEF];
      bus_write_type    step_writes [$];
      bus_write_type    writes_due [$];
      int               errors;

      function new();
         sweep_on = 1'b0;
         next_col = '0;
         gain     = GAIN_RESET;
         offset   = '0;
         foreach (trace_row[i]) trace_row[i] = '0;
         errors   = 0;
      endfunction

      function void add_point(logic chip, logic [5:0] caddr, logic [2:0] page,
                              logic [7:0] dbyte);
         step_writes.push_back('{chip, 1'b0, PAGE_CMD + {5'd0, page}, 1'b0});
         step_writes.push_back('{chip, 1'b0, COL_CMD + {2'd0, caddr}, 1'b0});
         step_writes.push_back('{chip, 1'b1, dbyte, 1'b0});
      endfunction

      function void note_byte(logic [7:0] x);
         bit [6:0]      col;
         logic          chip;
         logic [5:0]    caddr;
         bit            hidden;
         logic [2:0]    page;
         int            num;
         int            q;
         logic [5:0]    row;
         logic [7:0]    dbyte;
         bus_write_type w;
         if (!sweep_on) begin
            case (x)
               CHAR_GAIN_UP:   if (gain != GAIN_MAX) gain = gain + 8'd1;
               CHAR_GAIN_DOWN: if (gain != 8'd0) gain = gain - 8'd1;
               CHAR_OFFSET_UP: if (offset != OFFSET_MAX) offset = offset + 8'sd1;
               CHAR_OFFSET_DN: if (offset != OFFSET_MIN) offset = offset - 8'sd1;
               CHAR_SWEEP: begin
                  sweep_on = 1'b1;
                  next_col = '0;
               end
               default: ;
            endcase
            return;
         end
         step_writes.delete();
         col    = next_col;
         chip   = (col < HALF_COLUMNS_DEF);
         caddr  = col[5:0];
         hidden = (col == HALF_COLUMNS_DEF - 1);
         page   = trace_row[col][5:3];
         if (!hidden) add_point(chip, caddr, page, (page == PAGE_AXIS) ? AXIS_BIT : 8'h00);
         num = int'(x) * int'(gain) + 100 * int'(offset);
         if (num > -40 && num < 2560) begin
            q     = (num > 0) ? num / 40 : 0;
            row   = ROW_MAX - 6'(q);
            dbyte = 8'd1 << row[2:0];
            if (row >= ROW_AXIS_LO && row <= ROW_AXIS_HI) dbyte = dbyte + AXIS_BIT;
            trace_row[col] = row;
            if (!hidden) add_point(chip, caddr, row[5:3], dbyte);
         end
         if (col == COLUMNS_DEF - 1) sweep_on = 1'b0;
         next_col = col + 7'd1;
         for (int i = 0; i < step_writes.size(); i++) begin
            w      = step_writes[i];
            w.last = (i == step_writes.size() - 1);
            writes_due.push_back(w);
         end
      endfunction

      function void check_write(logic chip, logic is_data, logic [7:0] b, logic last);
         bus_write_type got;
         bus_write_type want;
         got = '{chip, is_data, b, last};
         if (writes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected write: chip %0d data %0d byte %h last %0d",
                        chip, is_data, b, last);
            return;
         end
         want = writes_due.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("write mismatch: expected chip %0d data %0d byte %h last %0d",
                        want.chip_sel, want.is_data, want.bus_byte, want.last);
               $display("                got chip %0d data %0d byte %h last %0d",
                        chip, is_data, b, last);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] bus_byte
   logic [1:0] rsp_tuser;           // [0] chip_sel, [1] is_data
   logic       rsp_tlast;

   bit req_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   int quiet_cycles = 0;
   plot_scoreboard sb = new();

   scope_trace_plotter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !rsp_idle_en || ($urandom_range(0, 99) >= 26);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_write(rsp_tuser[0], rsp_tuser[1], rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("** scope_trace_plotter: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (req_idle_en && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_noise();
      logic [7:0] b;
      do begin
         b = 8'($urandom);
      end while (b == CHAR_GAIN_UP || b == CHAR_GAIN_DOWN || b == CHAR_OFFSET_UP ||
                 b == CHAR_OFFSET_DN || b == CHAR_SWEEP);
      send_byte(b);
   endtask

   task automatic send_samples(input int count);
      int         lim;
      logic [7:0] x;
      lim = 255;
      if (sb.gain != 0 && 2600 / int'(sb.gain) < 255) lim = 2600 / int'(sb.gain);
      repeat (count) begin
         case ($urandom_range(0, 7))
            0:       x = CMD_CHARS[$urandom_range(0, 4)];
            1, 2:    x = 8'($urandom);
            default: x = 8'($urandom_range(0, lim));
         endcase
         send_byte(x);
      end
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.writes_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      // default gain and offset; first two columns land on axis rows
      send_byte(CHAR_SWEEP);
      send_byte(8'd100);
      send_byte(8'd120);
      send_samples(COLUMNS_DEF - 2);

      // gain saturates at zero, then back to gain 1 with offset -1
      wait_results_done();
      send_noise();
      repeat (11) send_byte(CHAR_GAIN_DOWN);
      send_byte(CHAR_GAIN_UP);
      send_byte(CHAR_OFFSET_DN);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_byte(CHAR_SWEEP);
      foreach (PROBE_SAMPLES[i]) send_byte(PROBE_SAMPLES[i]);
      send_samples(48);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.writes_due.size() == 0) begin
         $display("** scope_trace_plotter: PASSED **");
      end else begin
         $display("** scope_trace_plotter: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/stp_pkg.sv
rtl/stp_ram.sv
rtl/stp_queue.sv
rtl/stp_front.sv
rtl/stp_back.sv
rtl/scope_trace_plotter.sv
verif/scope_trace_plotter_tb.sv
